### src/assert_macros.svh
// Assertion macros used by the deframer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted.
`define SPD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spd assertion failed");
// Checked property, evaluated in and out of reset.
`define SPD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("spd assertion failed");
`else
`define SPD_ASSERT(name, clk, rst_n, prop)
`define SPD_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### src/spd_pkg.sv
package spd_pkg;

    // Packet layout.
    localparam int PACKET_BYTES = 16;
    localparam int POSITION_AT  = 2;
    localparam int LEFT_AT      = 6;
    localparam int RIGHT_AT     = 8;
    localparam int SERVO_AT     = 10;

    // Packet store geometry and byte counter width.
    localparam int STORE_AW    = $clog2(PACKET_BYTES);
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int IDX_W       = $clog2(PACKET_BYTES + 1);

    // Checksum words ahead of the two trailing checksum bytes.
    localparam int CSUM_WORDS = (PACKET_BYTES - 2) / 2;

    // Microprogram length and step counter width.
    localparam int PROG_LEN = 2 * CSUM_WORDS + 16;
    localparam int STEP_W   = $clog2(PROG_LEN + 1);

    // Position bias removed from the raw packet word.
    localparam logic [31:0] POS_BIAS = 32'h4000_0000;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration reset values.
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'd0;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'd0;
    localparam logic [7:0]  HOLD_LIMIT_RST  = 8'd30;
    localparam logic [15:0] OPEN_BELOW_RST  = 16'd100;
    localparam logic [15:0] BAND_LOW_RST    = 16'd170;
    localparam logic [15:0] BAND_HIGH_RST   = 16'd200;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYNC_FIRST,
        CFG_SYNC_SECOND,
        CFG_HOLD_LIMIT,
        CFG_OPEN_BELOW,
        CFG_BAND_LOW,
        CFG_BAND_HIGH
    } cfg_index_t;

    typedef enum logic [1:0] {
        GRIP_OPEN,
        GRIP_CLOSED,
        GRIP_MOVING,
        GRIP_HOLDING
    } grip_t;

    typedef enum logic [1:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_COLLECT,
        PH_CHECK
    } phase_t;

    // Datapath operations, applied to the byte read by the same step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACC_LO,
        OP_ACC_HI,
        OP_FOLD,
        OP_CHK_LO,
        OP_CHK_HI,
        OP_SKIP_IF_BAD,
        OP_LD_POS,
        OP_LD_LEFT,
        OP_LD_RIGHT,
        OP_LD_SERVO,
        OP_STATUS,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic [STORE_AW-1:0] addr;
        op_t                 op;
    } ctrl_t;

    // Control store: one control word per microprogram step.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        int    s;
        int    b;
        ctrl_t cw;
        s = int'(step);
        b = 2 * CSUM_WORDS;
        cw.addr = '0;
        cw.op   = OP_NOP;
        if (s < b) begin
            cw.addr = STORE_AW'(s);
            cw.op   = step[0] ? OP_ACC_HI : OP_ACC_LO;
        end
        else if (s == b) begin
            cw.op = OP_FOLD;
        end
        else if (s == b + 1) begin
            cw.addr = STORE_AW'(PACKET_BYTES - 2);
            cw.op   = OP_CHK_LO;
        end
        else if (s == b + 2) begin
            cw.addr = STORE_AW'(PACKET_BYTES - 1);
            cw.op   = OP_CHK_HI;
        end
        else if (s == b + 3) begin
            cw.op = OP_SKIP_IF_BAD;
        end
        else if (s < b + 8) begin
            cw.addr = STORE_AW'(POSITION_AT + s - (b + 4));
            cw.op   = OP_LD_POS;
        end
        else if (s < b + 10) begin
            cw.addr = STORE_AW'(LEFT_AT + s - (b + 8));
            cw.op   = OP_LD_LEFT;
        end
        else if (s < b + 12) begin
            cw.addr = STORE_AW'(RIGHT_AT + s - (b + 10));
            cw.op   = OP_LD_RIGHT;
        end
        else if (s < b + 14) begin
            cw.addr = STORE_AW'(SERVO_AT + s - (b + 12));
            cw.op   = OP_LD_SERVO;
        end
        else if (s == b + 14) begin
            cw.op = OP_STATUS;
        end
        else if (s == b + 15) begin
            cw.op = OP_EMIT;
        end
        return cw;
    endfunction

endpackage

### src/spd_if.sv
// Received byte channel.
interface spd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded packet channel.
interface spd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic [15:0]        left_range;
    logic [15:0]        right_range;
    logic [15:0]        servo_position;
    logic [1:0]         grip_status;

    modport source (
        output valid, output position, output left_range, output right_range,
        output servo_position, output grip_status, input ready
    );
    modport sink (
        input valid, input position, input left_range, input right_range,
        input servo_position, input grip_status, output ready
    );
endinterface

// Configuration write channel.
interface spd_cfg_if;
    import spd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/sensor_packet_deframer_core.sv
// Byte-serial packet deframer. One received byte is taken per request; rx.ready
// stays high while hunting for the two sync bytes and while collecting, so bytes
// go in at one per clock. When the last byte of a packet arrives, rx.ready drops
// while a microprogram reads the packet store back one byte per cycle through its
// single read port: it forms the checksum, compares it with the trailing bytes, and
// on a match extracts the fields and grip status into the result register. A good
// packet holds rx.ready low until the emit step writes its result; a packet with a
// bad checksum produces no result and ends the pause at the skip step after the
// checksum compare. The pause grows if the previous result has not yet been taken.
// The packet store has no reset; configuration is written through cfg at any idle
// time.
`include "assert_macros.svh"

module sensor_packet_deframer_core (
    input  logic         clk,
    input  logic         rst_n,
    spd_byte_if.sink     rx,
    spd_result_if.source pkt,
    spd_cfg_if.sink      cfg
);
    import spd_pkg::*;

    // Configuration registers.
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  hold_limit_reg;
    logic [15:0] open_below_reg;
    logic [15:0] band_low_reg;
    logic [15:0] band_high_reg;

    // Sequencer control.
    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    op_t               op_d_reg, op_d_next;

    // Datapath.
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  lo_reg, lo_next;
    logic [14:0] sum_reg, sum_next;
    logic        ok_reg, ok_next;
    logic [31:0] pos_reg, pos_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] right_reg, right_next;
    logic [15:0] servo_reg, servo_next;
    grip_t       status_reg, status_next;
    logic [7:0]  band_count_reg, band_count_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_position_reg, out_position_next;
    logic [15:0]        out_left_reg, out_left_next;
    logic [15:0]        out_right_reg, out_right_next;
    logic [15:0]        out_servo_reg, out_servo_next;
    grip_t              out_grip_reg, out_grip_next;

    logic                rx_fire;
    logic                hold;
    logic                start;
    logic [IDX_W-1:0]    idx_inc;
    ctrl_t               ctrl;
    logic                ram_wr_en;
    logic [7:0]          ram_rdata;
    logic                in_band;
    logic [7:0]          cnt_inc;

    assign rx_fire = rx.valid && rx.ready;
    assign idx_inc = idx_reg + 1'b1;
    assign start   = rx_fire && (phase_reg == PH_COLLECT) && (idx_inc == IDX_W'(PACKET_BYTES));
    assign ctrl    = ucode(step_reg);

    // The emit step waits while the previous result is still pending.
    assign hold = (op_d_reg == OP_EMIT) && out_valid_reg && !pkt.ready;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            hold_limit_reg  <= HOLD_LIMIT_RST;
            open_below_reg  <= OPEN_BELOW_RST;
            band_low_reg    <= BAND_LOW_RST;
            band_high_reg   <= BAND_HIGH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg.data[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg.data[7:0];
                CFG_HOLD_LIMIT:  hold_limit_reg  <= cfg.data[7:0];
                CFG_OPEN_BELOW:  open_below_reg  <= cfg.data;
                CFG_BAND_LOW:    band_low_reg    <= cfg.data;
                CFG_BAND_HIGH:   band_high_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // Next state: sync hunt, collection and microprogram sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        op_d_next  = op_d_reg;
        case (phase_reg)
            PH_HUNT0:
            begin
                if (rx_fire && (rx.rx_byte == sync_first_reg))
                begin
                    phase_next = PH_HUNT1;
                    idx_next   = IDX_W'(1);
                end
            end
            PH_HUNT1:
            begin
                if (rx_fire)
                begin
                    if (rx.rx_byte == sync_second_reg)
                    begin
                        phase_next = PH_COLLECT;
                        idx_next   = IDX_W'(2);
                    end
                    else
                    begin
                        phase_next = PH_HUNT0;
                        idx_next   = '0;
                    end
                end
            end
            PH_COLLECT:
            begin
                if (rx_fire)
                begin
                    idx_next = idx_inc;
                    if (start)
                    begin
                        phase_next = PH_CHECK;
                        idx_next   = '0;
                        step_next  = '0;
                        op_d_next  = OP_NOP;
                    end
                end
            end
            PH_CHECK:
            begin
                if (!hold)
                begin
                    if (step_reg < STEP_W'(PROG_LEN))
                    begin
                        op_d_next = ctrl.op;
                        step_next = step_reg + 1'b1;
                    end
                    else
                    begin
                        op_d_next = OP_NOP;
                    end
                    if ((op_d_reg == OP_SKIP_IF_BAD && !ok_reg) || op_d_reg == OP_EMIT)
                    begin
                        phase_next = PH_HUNT0;
                        step_next  = '0;
                        op_d_next  = OP_NOP;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT0;
            end
        endcase
    end

    // Outputs of the control: byte acceptance and store writes.
    always_comb
    begin
        rx.ready  = (phase_reg != PH_CHECK);
        ram_wr_en = 1'b0;
        case (phase_reg)
            PH_HUNT0:   ram_wr_en = rx_fire && (rx.rx_byte == sync_first_reg);
            PH_HUNT1:   ram_wr_en = rx_fire && (rx.rx_byte == sync_second_reg);
            PH_COLLECT: ram_wr_en = rx_fire;
            default:    ram_wr_en = 1'b0;
        endcase
    end

    // Packet store; write address follows the byte counter.
    spd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg[STORE_AW-1:0]),
        .wr_data (rx.rx_byte),
        .rd_addr (ctrl.addr),
        .rd_data (ram_rdata)
    );

    // Grip band test on the extracted servo position.
    assign in_band = (servo_reg < band_high_reg) && (servo_reg > band_low_reg);
    assign cnt_inc = (band_count_reg == 8'hFF) ? band_count_reg : band_count_reg + 8'd1;

    // Datapath: apply the delayed operation to the byte just read.
    always_comb
    begin
        acc_next          = start ? '0 : acc_reg;
        lo_next           = lo_reg;
        sum_next          = sum_reg;
        ok_next           = ok_reg;
        pos_next          = pos_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        servo_next        = servo_reg;
        status_next       = status_reg;
        band_count_next   = band_count_reg;
        out_valid_next    = out_valid_reg;
        out_position_next = out_position_reg;
        out_left_next     = out_left_reg;
        out_right_next    = out_right_reg;
        out_servo_next    = out_servo_reg;
        out_grip_next     = out_grip_reg;
        if (pkt.valid && pkt.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (op_d_reg)
            OP_ACC_LO:   lo_next = ram_rdata;
            OP_ACC_HI:   acc_next = {acc_reg[30:0], 1'b0} + {16'd0, ram_rdata, lo_reg};
            OP_FOLD:     sum_next = acc_reg[14:0] + acc_reg[29:15];
            OP_CHK_LO:   ok_next = (ram_rdata == sum_reg[7:0]);
            OP_CHK_HI:   ok_next = ok_reg && (ram_rdata == {1'b0, sum_reg[14:8]});
            OP_LD_POS:   pos_next = {ram_rdata, pos_reg[31:8]};
            OP_LD_LEFT:  left_next = {ram_rdata, left_reg[15:8]};
            OP_LD_RIGHT: right_next = {ram_rdata, right_reg[15:8]};
            OP_LD_SERVO: servo_next = {ram_rdata, servo_reg[15:8]};
            OP_STATUS:
            begin
                if (in_band)
                begin
                    band_count_next = cnt_inc;
                    status_next = (cnt_inc > hold_limit_reg) ? GRIP_HOLDING : GRIP_MOVING;
                end
                else
                begin
                    band_count_next = '0;
                    if (servo_reg < open_below_reg)
                    begin
                        status_next = GRIP_OPEN;
                    end
                    else if (servo_reg > band_high_reg)
                    begin
                        status_next = GRIP_CLOSED;
                    end
                    else
                    begin
                        status_next = GRIP_MOVING;
                    end
                end
            end
            OP_EMIT:
            begin
                if (!hold)
                begin
                    out_valid_next    = 1'b1;
                    out_position_next = $signed(pos_reg - POS_BIAS);
                    out_left_next     = left_reg;
                    out_right_next    = right_reg;
                    out_servo_next    = servo_reg;
                    out_grip_next     = status_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT0;
            idx_reg        <= '0;
            step_reg       <= '0;
            op_d_reg       <= OP_NOP;
            band_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            step_reg       <= step_next;
            op_d_reg       <= op_d_next;
            band_count_reg <= band_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        lo_reg           <= lo_next;
        sum_reg          <= sum_next;
        ok_reg           <= ok_next;
        pos_reg          <= pos_next;
        left_reg         <= left_next;
        right_reg        <= right_next;
        servo_reg        <= servo_next;
        status_reg       <= status_next;
        out_position_reg <= out_position_next;
        out_left_reg     <= out_left_next;
        out_right_reg    <= out_right_next;
        out_servo_reg    <= out_servo_next;
        out_grip_reg     <= out_grip_next;
    end

    // Result channel.
    assign pkt.valid          = out_valid_reg;
    assign pkt.position       = out_position_reg;
    assign pkt.left_range     = out_left_reg;
    assign pkt.right_range    = out_right_reg;
    assign pkt.servo_position = out_servo_reg;
    assign pkt.grip_status    = out_grip_reg;

    // A new result only appears after the emit step ran.
    `SPD_ASSERT(a_rose_after_emit, clk, rst_n, $rose(out_valid_reg) |-> $past(op_d_reg == OP_EMIT))
    // The check only starts on the final byte of a packet.
    `SPD_ASSERT(a_check_entry, clk, rst_n, (phase_reg == PH_CHECK && $past(phase_reg) != PH_CHECK) |-> $past(start))
    // Datapath operations run only while the microprogram is active.
    `SPD_ASSERT(a_ops_in_check, clk, rst_n, (op_d_reg != OP_NOP) |-> (phase_reg == PH_CHECK))
    // The band counter moves only on the status step.
    `SPD_ASSERT(a_band_on_status, clk, rst_n, !$stable(band_count_reg) |-> $past(op_d_reg == OP_STATUS))
    // The step counter never runs past the end of the program.
    `SPD_ASSERT(a_step_bound, clk, rst_n, step_reg <= STEP_W'(PROG_LEN))

endmodule

### src/spd_ram.sv
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### verif/sensor_packet_deframer_core_test.sv
module sensor_packet_deframer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam int HALF_PERIOD       = 5;
    localparam int RESET_CYCLES      = 7;
    localparam int GAP_MAX           = 13;
    localparam int HOLD_OFF_CYCLES   = 400;
    localparam int SETTLE_CYCLES     = 2 * PROG_LEN + 8;
    localparam int MAX_REPORTS       = 10;
    localparam int STORE_SLOTS       = 64;
    localparam int FILL_WRAP         = 128;
    localparam int HOLD_RUN_FRAMES   = 10;
    localparam int RUN_LIMIT_NS      = 5_000_000;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(7);

    typedef logic [7:0] frame_t [PACKET_BYTES];

    typedef struct packed {
        logic signed [31:0] position;
        logic [15:0]        left_range;
        logic [15:0]        right_range;
        logic [15:0]        servo_position;
        grip_t              grip_status;
    } reading_t;

    // Raw write data per register; the block keeps only the register's width.
    typedef struct packed {
        logic [15:0] sync_first;
        logic [15:0] sync_second;
        logic [15:0] hold_limit;
        logic [15:0] open_below;
        logic [15:0] band_low;
        logic [15:0] band_high;
    } setting_t;

    typedef enum logic [1:0] {
        ROW_PACKET,
        ROW_BAD_SUM,
        ROW_SYNC_MISS,
        ROW_BYTE
    } row_kind_t;

    // One directed step. A lone byte is taken from the low byte of pos_raw.
    typedef struct packed {
        logic [1:0]  setting;
        row_kind_t   kind;
        logic [31:0] pos_raw;
        logic [15:0] left_raw;
        logic [15:0] right_raw;
        logic [15:0] servo_raw;
        logic        typed;
        logic [31:0] want_position;
        grip_t       want_grip;
    } plan_row_t;

    // Setting 0 holds the reset values and is in force before any write.
    setting_t plan_settings [3] = '{
        '{16'h0000, 16'h0000, 16'h001E, 16'h0064, 16'h00AA, 16'h00C8},
        '{16'hFFA5, 16'h3C5A, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF},
        '{16'h00FF, 16'h00FF, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'h0000}
    };

    plan_row_t directed_plan [19] = '{
        '{2'd0, ROW_PACKET,    32'h4000_0000, 16'h0000, 16'hFFFF, 16'd0,
          1'b1, 32'h0000_0000, GRIP_OPEN},
        '{2'd0, ROW_PACKET,    32'h0000_0000, 16'hFFFF, 16'h0000, 16'hFFFF,
          1'b1, 32'hC000_0000, GRIP_CLOSED},
        '{2'd0, ROW_PACKET,    32'hC000_0000, 16'h1234, 16'h8000, 16'd200,
          1'b1, 32'h8000_0000, GRIP_MOVING},
        '{2'd0, ROW_PACKET,    32'h3FFF_FFFF, 16'h5555, 16'hAAAA, 16'd99,
          1'b1, 32'hFFFF_FFFF, GRIP_OPEN},
        '{2'd0, ROW_PACKET,    32'hBFFF_FFFF, 16'h00FF, 16'hFF00, 16'd185,
          1'b1, 32'h7FFF_FFFF, GRIP_MOVING},
        '{2'd0, ROW_BAD_SUM,   32'h4000_0000, 16'h0001, 16'h0002, 16'd185,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd0, ROW_PACKET,    32'h1234_5678, 16'h0101, 16'h0202, 16'd171,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd0, ROW_PACKET,    32'h8765_4321, 16'h0303, 16'h0404, 16'd170,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd0, ROW_PACKET,    32'hDEAD_BEEF, 16'h0505, 16'h0606, 16'd201,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd0, ROW_BYTE,      32'h0000_0080, 16'h0000, 16'h0000, 16'd0,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd1, ROW_SYNC_MISS, 32'h0000_0000, 16'h0000, 16'h0000, 16'd0,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd1, ROW_BYTE,      32'h0000_005A, 16'h0000, 16'h0000, 16'd0,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd1, ROW_PACKET,    32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd1,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd1, ROW_PACKET,    32'h0000_0001, 16'h0001, 16'h8001, 16'hFFFE,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd1, ROW_PACKET,    32'h7FFF_FFFF, 16'h7FFF, 16'h0000, 16'h0000,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd1, ROW_PACKET,    32'h8000_0000, 16'h8000, 16'h7FFF, 16'hFFFF,
          1'b0, 32'h0, GRIP_OPEN},
        '{2'd2, ROW_PACKET,    32'h4000_0000, 16'h0000, 16'h0000, 16'd300,
          1'b1, 32'h0000_0000, GRIP_OPEN},
        '{2'd2, ROW_PACKET,    32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 32'hBFFF_FFFF, GRIP_CLOSED},
        '{2'd2, ROW_BAD_SUM,   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b0, 32'h0, GRIP_OPEN}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spd_byte_if   rx_if ();
    spd_result_if pkt_if ();
    spd_cfg_if    cfg_if ();

    sensor_packet_deframer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .pkt   (pkt_if),
        .cfg   (cfg_if)
    );

    // Shadow copy of the configuration registers.
    logic [7:0]  cfg_sync_first  = SYNC_FIRST_RST;
    logic [7:0]  cfg_sync_second = SYNC_SECOND_RST;
    logic [7:0]  cfg_hold_limit  = HOLD_LIMIT_RST;
    logic [15:0] cfg_open_below  = OPEN_BELOW_RST;
    logic [15:0] cfg_band_low    = BAND_LOW_RST;
    logic [15:0] cfg_band_high   = BAND_HIGH_RST;

    // Deframer state as tracked by the testbench.
    phase_t      track_phase = PH_HUNT0;
    int          track_fill  = 0;
    logic [7:0]  frame_store [STORE_SLOTS] = '{default: 8'h00};
    logic [7:0]  in_band_run = 8'h00;

    reading_t    pending_readings [$];
    int          bad_readings       = 0;
    int          readings_predicted = 0;
    int          bytes_sent         = 0;
    int          src_gap_max        = GAP_MAX;
    int          sink_gap_max       = GAP_MAX;
    bit          hold_off_req       = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    // Folded 15-bit checksum over the words ahead of the two checksum bytes.
    function automatic logic [14:0] fold_sum(input frame_t f);
        logic [31:0] acc;
        logic [31:0] folded;
        int          k;
        acc = 32'h0;
        for (k = 0; k < CSUM_WORDS; k++)
            acc = (acc << 1) + {16'h0, f[2 * k + 1], f[2 * k]};
        folded = {17'h0, acc[14:0]} + (acc >> 15);
        return folded[14:0];
    endfunction

    function automatic logic [15:0] stored_word(input int at);
        return {frame_store[(at + 1) % STORE_SLOTS], frame_store[at % STORE_SLOTS]};
    endfunction

    // Advance the tracked deframer by one byte and queue the reading it yields.
    task automatic deframe_byte(input logic [7:0] b);
        frame_t      f;
        logic [14:0] s;
        logic [15:0] servo;
        reading_t    r;
        int          k;
        case (track_phase)
            PH_HUNT1:
            begin
                if (b == cfg_sync_second)
                begin
                    frame_store[1] = b;
                    track_fill     = 2;
                    track_phase    = PH_COLLECT;
                end
                else
                begin
                    // The mismatching byte is not retried as a first sync byte.
                    track_fill  = 0;
                    track_phase = PH_HUNT0;
                end
            end
            PH_COLLECT:
            begin
                frame_store[track_fill % STORE_SLOTS] = b;
                track_fill = (track_fill + 1) % FILL_WRAP;
                if (track_fill >= PACKET_BYTES)
                begin
                    for (k = 0; k < PACKET_BYTES; k++)
                        f[k] = frame_store[k];
                    s = fold_sum(f);
                    if (s[7:0] == f[PACKET_BYTES - 2] && {1'b0, s[14:8]} == f[PACKET_BYTES - 1])
                    begin
                        servo = stored_word(SERVO_AT);
                        if (servo < cfg_band_high && servo > cfg_band_low)
                        begin
                            if (in_band_run != 8'hFF)
                                in_band_run++;
                            r.grip_status = (in_band_run > cfg_hold_limit) ? GRIP_HOLDING
                                                                            : GRIP_MOVING;
                        end
                        else
                        begin
                            if (servo < cfg_open_below)
                                r.grip_status = GRIP_OPEN;
                            else if (servo > cfg_band_high)
                                r.grip_status = GRIP_CLOSED;
                            else
                                r.grip_status = GRIP_MOVING;
                            in_band_run = 8'h00;
                        end
                        r.position       = {stored_word(POSITION_AT + 2),
                                            stored_word(POSITION_AT)} - POS_BIAS;
                        r.left_range     = stored_word(LEFT_AT);
                        r.right_range    = stored_word(RIGHT_AT);
                        r.servo_position = servo;
                        pending_readings.insert(pending_readings.size(), r);
                        readings_predicted++;
                    end
                    track_fill  = 0;
                    track_phase = PH_HUNT0;
                end
            end
            default:
            begin
                track_phase = PH_HUNT0;
                if (b == cfg_sync_first)
                begin
                    frame_store[0] = b;
                    track_fill     = 1;
                    track_phase    = PH_HUNT1;
                end
            end
        endcase
    endtask

    // Build a packet with the current sync bytes and a good or broken checksum.
    function automatic frame_t make_frame(input logic [31:0] pos_raw,
                                          input logic [15:0] left_raw,
                                          input logic [15:0] right_raw,
                                          input logic [15:0] servo_raw,
                                          input bit          bad_sum);
        frame_t      f;
        logic [14:0] s;
        int          k;
        for (k = 0; k < PACKET_BYTES; k++)
            f[k] = 8'($urandom);
        f[0] = cfg_sync_first;
        f[1] = cfg_sync_second;
        {f[POSITION_AT + 3], f[POSITION_AT + 2], f[POSITION_AT + 1], f[POSITION_AT]} = pos_raw;
        {f[LEFT_AT + 1], f[LEFT_AT]}   = left_raw;
        {f[RIGHT_AT + 1], f[RIGHT_AT]} = right_raw;
        {f[SERVO_AT + 1], f[SERVO_AT]} = servo_raw;
        s = fold_sum(f);
        f[PACKET_BYTES - 2] = s[7:0];
        f[PACKET_BYTES - 1] = {1'b0, s[14:8]};
        if (bad_sum)
            f[PACKET_BYTES - 2 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        return f;
    endfunction

    // Servo values near the band and open edges, weighted toward the band.
    function automatic logic [15:0] pick_servo();
        case ($urandom_range(0, 11))
            0:       return cfg_band_low;
            1:       return 16'(cfg_band_low + 1);
            2:       return 16'(cfg_band_high - 1);
            3:       return cfg_band_high;
            4:       return 16'(cfg_band_high + 1);
            5:       return 16'(cfg_open_below - 1);
            6:       return cfg_open_below;
            7:       return 16'($urandom);
            default:
            begin
                if (cfg_band_high > cfg_band_low + 1)
                    return 16'($urandom_range(cfg_band_low + 1, cfg_band_high - 1));
                return 16'($urandom);
            end
        endcase
    endfunction

    // Offer one byte after a random idle gap and track it once the request is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_t f);
        int k;
        for (k = 0; k < PACKET_BYTES; k++)
            send_byte(f[k]);
    endtask

    // One register write request; the shadow keeps only the register's width.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            CFG_SYNC_FIRST:  cfg_sync_first  = val[7:0];
            CFG_SYNC_SECOND: cfg_sync_second = val[7:0];
            CFG_HOLD_LIMIT:  cfg_hold_limit  = val[7:0];
            CFG_OPEN_BELOW:  cfg_open_below  = val;
            CFG_BAND_LOW:    cfg_band_low    = val;
            CFG_BAND_HIGH:   cfg_band_high   = val;
            default:         ;
        endcase
    endtask

    task automatic apply_setting(input setting_t s);
        write_reg(CFG_SPARE_A, 16'($urandom));
        write_reg(CFG_SPARE_B, 16'($urandom));
        write_reg(CFG_SYNC_FIRST, s.sync_first);
        write_reg(CFG_SYNC_SECOND, s.sync_second);
        write_reg(CFG_HOLD_LIMIT, s.hold_limit);
        write_reg(CFG_OPEN_BELOW, s.open_below);
        write_reg(CFG_BAND_LOW, s.band_low);
        write_reg(CFG_BAND_HIGH, s.band_high);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every predicted reading, then for a packet check that yields nothing.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic setting_t random_setting(input bit wide);
        setting_t s;
        s.sync_first  = 16'($urandom);
        s.sync_second = 16'($urandom);
        if (wide)
        begin
            s.hold_limit = 16'($urandom);
            s.open_below = 16'($urandom);
            s.band_low   = 16'($urandom);
            s.band_high  = 16'($urandom);
        end
        else
        begin
            s.hold_limit = {8'($urandom), 8'($urandom_range(0, 4))};
            s.band_low   = 16'($urandom_range(0, 2000));
            s.band_high  = s.band_low + 16'($urandom_range(2, 80));
            s.open_below = 16'($urandom_range(0, s.band_low + 10));
        end
        return s;
    endfunction

    // Mostly well-formed packets, with broken checksums, sync misses, noise and cut packets.
    task automatic run_phase(input setting_t s, input int budget, input bit src_idle,
                             input bit sink_idle, input bit with_hold);
        int start;
        int pick;
        settle();
        apply_setting(s);
        sink_gap_max = sink_idle ? GAP_MAX : 0;
        hold_off_req = with_hold;
        start        = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            src_gap_max = (src_idle && $urandom_range(0, 3) != 0) ? GAP_MAX : 0;
            pick        = $urandom_range(0, 99);
            if (pick < 68)
                send_frame(make_frame($urandom, 16'($urandom), 16'($urandom),
                                      pick_servo(), 1'b0));
            else if (pick < 78)
                send_frame(make_frame($urandom, 16'($urandom), 16'($urandom),
                                      pick_servo(), 1'b1));
            else if (pick < 86)
            begin
                send_byte(cfg_sync_first);
                send_byte(cfg_sync_second ^ 8'($urandom_range(1, 255)));
            end
            else if (pick < 93)
                send_byte(8'($urandom));
            else
            begin
                send_byte(cfg_sync_first);
                send_byte(cfg_sync_second);
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
            end
        end
    endtask

    // Compare each accepted result request with the oldest predicted reading.
    always @(posedge clk)
    begin
        reading_t want;
        reading_t seen;
        if (rst_n && pkt_if.valid && pkt_if.ready)
        begin
            seen.position       = pkt_if.position;
            seen.left_range     = pkt_if.left_range;
            seen.right_range    = pkt_if.right_range;
            seen.servo_position = pkt_if.servo_position;
            seen.grip_status    = grip_t'(pkt_if.grip_status);
            if (pending_readings.size() == 0)
            begin
                bad_readings++;
                if (bad_readings <= MAX_REPORTS)
                    $display("unexpected reading: pos %0d left %0d right %0d servo %0d grip %0d",
                             seen.position, seen.left_range, seen.right_range,
                             seen.servo_position, seen.grip_status);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (seen !== want)
                begin
                    bad_readings++;
                    if (bad_readings <= MAX_REPORTS)
                    begin
                        $display("reading mismatch: expected pos %0d left %0d right %0d %s",
                                 want.position, want.left_range, want.right_range, "");
                        $display("  expected servo %0d grip %0d", want.servo_position,
                                 want.grip_status);
                        $display("  got pos %0d left %0d right %0d servo %0d grip %0d",
                                 seen.position, seen.left_range, seen.right_range,
                                 seen.servo_position, seen.grip_status);
                    end
                end
            end
        end
    end

    // Result side: a random stall before each request, or one long hold-off when asked.
    initial
    begin
        int stall;
        pkt_if.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                stall = $urandom_range(0, sink_gap_max);
            if (stall > 0)
            begin
                pkt_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pkt_if.ready <= 1'b1;
            @(posedge clk);
            while (!pkt_if.valid)
                @(posedge clk);
        end
    end

    // Main sequence: reset, directed table, run into holding, random phases.
    initial
    begin
        plan_row_t row;
        setting_t  hold_set;
        reading_t  typed_want;
        int        active_setting;
        int        made_before;
        int        i;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed rows carry an expectation read straight off the spec.
        active_setting = 0;
        for (i = 0; i < $size(directed_plan); i++)
        begin
            row = directed_plan[i];
            if (int'(row.setting) != active_setting)
            begin
                settle();
                apply_setting(plan_settings[row.setting]);
                active_setting = int'(row.setting);
            end
            src_gap_max = (i % 3 == 0) ? 0 : GAP_MAX;
            case (row.kind)
                ROW_PACKET, ROW_BAD_SUM:
                begin
                    made_before = readings_predicted;
                    send_frame(make_frame(row.pos_raw, row.left_raw, row.right_raw,
                                          row.servo_raw, row.kind == ROW_BAD_SUM));
                    if (row.typed)
                    begin
                        if (readings_predicted == made_before + 1)
                            void'(pending_readings.pop_back());
                        typed_want = '{row.want_position, row.left_raw, row.right_raw,
                                       row.servo_raw, row.want_grip};
                        pending_readings.insert(pending_readings.size(), typed_want);
                    end
                end
                ROW_SYNC_MISS:
                begin
                    send_byte(cfg_sync_first);
                    send_byte((cfg_sync_first != cfg_sync_second) ? cfg_sync_first
                                                                  : ~cfg_sync_second);
                end
                default:
                    send_byte(row.pos_raw[7:0]);
            endcase
        end

        // A run of in-band packets carries the band counter past the hold limit.
        settle();
        hold_set.sync_first  = 16'($urandom);
        hold_set.sync_second = 16'($urandom);
        hold_set.hold_limit  = 16'h5A05;
        hold_set.open_below  = 16'd5;
        hold_set.band_low    = 16'd10;
        hold_set.band_high   = 16'd20;
        apply_setting(hold_set);
        src_gap_max = 0;
        repeat (HOLD_RUN_FRAMES)
            send_frame(make_frame($urandom, 16'($urandom), 16'($urandom),
                                  16'($urandom_range(11, 19)), 1'b0));
        send_frame(make_frame($urandom, 16'($urandom), 16'($urandom), 16'd20, 1'b0));

        // Random phases under several settings, one with a long result hold-off.
        run_phase(random_setting(1'b0), 120, 1'b1, 1'b1, 1'b0);
        run_phase(random_setting(1'b0), 120, 1'b0, 1'b1, 1'b1);
        run_phase(random_setting(1'b1), 110, 1'b1, 1'b0, 1'b0);
        run_phase(random_setting(1'b0), 110, 1'b1, 1'b1, 1'b0);

        settle();
        if (bad_readings == 0)
            $display("sensor_packet_deframer_core_test passed");
        else
            $display("sensor_packet_deframer_core_test failed");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("sensor_packet_deframer_core_test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/spd_pkg.sv
src/spd_if.sv
src/spd_ram.sv
src/sensor_packet_deframer_core.sv
verif/sensor_packet_deframer_core_test.sv
